FILE: rtl/cwk_pkg.sv
// Shared types, codes and the speed table of the CW keyer.
// Used by cwk_cfg, cwk_keyer and the top level in rtl/; depends on nothing.
package cwk_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_PADDLE_MODE = 3'd0;
  localparam logic [2:0] REG_WPM         = 3'd1;
  localparam logic [2:0] REG_CLASS_MULT  = 3'd2;
  localparam logic [2:0] REG_SWAP        = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE    = 3'd4;

  localparam logic [5:0] WPM_MIN = 6'd5;
  localparam logic [5:0] WPM_MAX = 6'd60;
  localparam logic [5:0] WPM_RST = 6'd20;
  localparam logic [7:0] DIT_RST = 8'd60;
  localparam logic [7:0] MULT_RST = 8'd32;
  localparam logic [7:0] DEBOUNCE_RST = 8'd5;

  // Event codes on the result stream.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;

  // Key state codes on the result stream.
  localparam logic [1:0] KS_IDLE = 2'd0;
  localparam logic [1:0] KS_DIT  = 2'd1;
  localparam logic [1:0] KS_DAH  = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SEND  = 2'd1,
    PH_SPACE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EL_NONE = 2'd0,
    EL_DIT  = 2'd1,
    EL_DAH  = 2'd2
  } elem_t;

  typedef struct packed {
    logic        paddle_mode;
    logic        paddle_swap;
    logic [7:0]  settle_ms;
    logic [7:0]  dit_len;
    logic [11:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic        ring_pressed;
    logic        tip_pressed;
    logic [1:0]  key_state;
    logic [11:0] threshold_ms;
    logic [31:0] element_ms;
    logic        element_is_dah;
    logic [1:0]  event_code;
    logic        transmit_on;
  } res_t;

  // Dit length in ms for a speed already clamped to 5..60 (1200 / wpm, truncated).
  function automatic logic [7:0] dit_len_lut(input logic [5:0] wpm);
    logic [7:0] d;
    case (wpm)
      6'd5:  d = 8'd240;
      6'd6:  d = 8'd200;
      6'd7:  d = 8'd171;
      6'd8:  d = 8'd150;
      6'd9:  d = 8'd133;
      6'd10: d = 8'd120;
      6'd11: d = 8'd109;
      6'd12: d = 8'd100;
      6'd13: d = 8'd92;
      6'd14: d = 8'd85;
      6'd15: d = 8'd80;
      6'd16: d = 8'd75;
      6'd17: d = 8'd70;
      6'd18: d = 8'd66;
      6'd19: d = 8'd63;
      6'd20: d = 8'd60;
      6'd21: d = 8'd57;
      6'd22: d = 8'd54;
      6'd23: d = 8'd52;
      6'd24: d = 8'd50;
      6'd25: d = 8'd48;
      6'd26: d = 8'd46;
      6'd27: d = 8'd44;
      6'd28: d = 8'd42;
      6'd29: d = 8'd41;
      6'd30: d = 8'd40;
      6'd31: d = 8'd38;
      6'd32: d = 8'd37;
      6'd33: d = 8'd36;
      6'd34: d = 8'd35;
      6'd35: d = 8'd34;
      6'd36: d = 8'd33;
      6'd37: d = 8'd32;
      6'd38: d = 8'd31;
      6'd39: d = 8'd30;
      6'd40: d = 8'd30;
      6'd41: d = 8'd29;
      6'd42: d = 8'd28;
      6'd43: d = 8'd27;
      6'd44: d = 8'd27;
      6'd45: d = 8'd26;
      6'd46: d = 8'd26;
      6'd47: d = 8'd25;
      6'd48: d = 8'd25;
      6'd49: d = 8'd24;
      6'd50: d = 8'd24;
      6'd51: d = 8'd23;
      6'd52: d = 8'd23;
      6'd53: d = 8'd22;
      6'd54: d = 8'd22;
      6'd55: d = 8'd21;
      6'd56: d = 8'd21;
      6'd57: d = 8'd21;
      6'd58: d = 8'd20;
      6'd59: d = 8'd20;
      6'd60: d = 8'd20;
      default: d = DIT_RST;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/cwk_cfg.sv
// Configuration registers of the CW keyer, with dit length and threshold kept precomputed.
// Depends on cwk_pkg.
module cwk_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [7:0]          wr_data,
  output cwk_pkg::cfg_t       cfg,
  output logic                keyer_clear
);

  logic       paddle_mode;
  logic       paddle_swap;
  logic [7:0] settle_ms;
  logic [7:0] dit_len;
  logic [7:0] class_mult;
  logic [11:0] threshold;
  logic [5:0] wpm_clamped;
  logic [7:0] dit_new;
  logic [15:0] thr_wpm;
  logic [15:0] thr_mult;

  always_comb begin
    wpm_clamped = wr_data[5:0];
    if (wr_data[5:0] < cwk_pkg::WPM_MIN) begin
      wpm_clamped = cwk_pkg::WPM_MIN;
    end else if (wr_data[5:0] > cwk_pkg::WPM_MAX) begin
      wpm_clamped = cwk_pkg::WPM_MAX;
    end
    dit_new  = cwk_pkg::dit_len_lut(wpm_clamped);
    thr_wpm  = {8'd0, dit_new} * {8'd0, class_mult};
    thr_mult = {8'd0, dit_len} * {8'd0, wr_data};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      paddle_mode <= 1'b0;
      paddle_swap <= 1'b0;
      settle_ms   <= cwk_pkg::DEBOUNCE_RST;
      dit_len     <= cwk_pkg::DIT_RST;
      class_mult  <= cwk_pkg::MULT_RST;
      threshold   <= 12'(({8'd0, cwk_pkg::DIT_RST} * {8'd0, cwk_pkg::MULT_RST}) >> 4);
    end else if (wr_en) begin
      unique case (wr_index)
        cwk_pkg::REG_PADDLE_MODE: paddle_mode <= wr_data[0];
        cwk_pkg::REG_WPM: begin
          dit_len   <= dit_new;
          threshold <= thr_wpm[15:4];
        end
        cwk_pkg::REG_CLASS_MULT: begin
          class_mult <= wr_data;
          threshold  <= thr_mult[15:4];
        end
        cwk_pkg::REG_SWAP:     paddle_swap <= wr_data[0];
        cwk_pkg::REG_DEBOUNCE: settle_ms <= wr_data;
        default: ;
      endcase
    end
  end

  assign keyer_clear = wr_en && (wr_index == cwk_pkg::REG_PADDLE_MODE);

  assign cfg.paddle_mode = paddle_mode;
  assign cfg.paddle_swap = paddle_swap;
  assign cfg.settle_ms   = settle_ms;
  assign cfg.dit_len     = dit_len;
  assign cfg.threshold   = threshold;

endmodule

FILE: rtl/cwk_debounce.sv
// Time-based debouncer for one active-low contact.
// Depends on nothing but its ports; the pressed output reflects this tick's update.
module cwk_debounce #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick,
  input  logic                  raw,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic [7:0]            settle_ms,
  output logic                  pressed
);

  logic                  stable, stable_next;
  logic                  last_raw, last_raw_next;
  logic [TIME_WIDTH-1:0] change_time, change_time_next;
  logic [TIME_WIDTH-1:0] held;

  always_comb begin
    last_raw_next    = last_raw;
    change_time_next = change_time;
    if (raw != last_raw) begin
      last_raw_next    = raw;
      change_time_next = now;
    end
    held        = now - change_time_next;
    stable_next = (held >= TIME_WIDTH'(settle_ms)) ? last_raw_next : stable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable      <= 1'b1;
      last_raw    <= 1'b1;
      change_time <= '0;
    end else if (tick) begin
      stable      <= stable_next;
      last_raw    <= last_raw_next;
      change_time <= change_time_next;
    end
  end

  assign pressed = !stable_next;

endmodule

FILE: rtl/cwk_keyer.sv
// Straight-key timer and iambic paddle state machine, one tick per call.
// Depends on cwk_pkg; takes debounced contacts and produces one result per tick.
module cwk_keyer #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick,
  input  logic                  clear,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic                  tip,
  input  logic                  ring,
  input  cwk_pkg::cfg_t         cfg,
  output cwk_pkg::res_t         res
);

  cwk_pkg::phase_t       phase, phase_next;
  cwk_pkg::elem_t        elem, elem_next;
  cwk_pkg::elem_t        start_el;
  logic [TIME_WIDTH-1:0] phase_start, phase_start_next;
  logic [TIME_WIDTH-1:0] key_down, key_down_next;
  logic [9:0]            elem_len, elem_len_next;
  logic                  dit_mem, dit_mem_next;
  logic                  dah_mem, dah_mem_next;
  logic                  tx, tx_next;

  logic                  dit, dah;
  logic                  in_send, in_space, in_idle;
  logic                  dit_mem_upd, dah_mem_upd;
  logic [TIME_WIDTH-1:0] phase_diff, key_diff, key_diff_next;
  logic                  send_end, space_end, start_go, go_idle;
  logic                  straight_start, straight_end;
  logic [TIME_WIDTH-1:0] thr_w;

  // Decisions shared by the next-state and the output logic.
  always_comb begin
    dit      = cfg.paddle_swap ? ring : tip;
    dah      = cfg.paddle_swap ? tip : ring;
    in_send  = (phase == cwk_pkg::PH_SEND);
    in_space = (phase == cwk_pkg::PH_SPACE);
    in_idle  = !in_send && !in_space;
    thr_w    = TIME_WIDTH'(cfg.threshold);

    dit_mem_upd = dit_mem || ((in_send || in_space) && elem == cwk_pkg::EL_DAH && dit);
    dah_mem_upd = dah_mem || ((in_send || in_space) && elem == cwk_pkg::EL_DIT && dah);

    phase_diff = now - phase_start;
    key_diff   = now - key_down;
    send_end   = in_send && (phase_diff >= TIME_WIDTH'(elem_len));
    space_end  = in_space && (phase_diff >= TIME_WIDTH'(cfg.dit_len));

    start_go = 1'b0;
    go_idle  = 1'b0;
    start_el = cwk_pkg::EL_DIT;
    if (space_end) begin
      start_go = 1'b1;
      if (dah_mem_upd) begin
        start_el = cwk_pkg::EL_DAH;
      end else if (dit_mem_upd) begin
        start_el = cwk_pkg::EL_DIT;
      end else if (dit && dah) begin
        // Squeeze: alternate against the element just sent.
        start_el = (elem == cwk_pkg::EL_DIT) ? cwk_pkg::EL_DAH : cwk_pkg::EL_DIT;
      end else if (dit) begin
        start_el = cwk_pkg::EL_DIT;
      end else if (dah) begin
        start_el = cwk_pkg::EL_DAH;
      end else begin
        start_go = 1'b0;
        go_idle  = 1'b1;
      end
    end else if (in_idle) begin
      start_go = dit || dah;
      start_el = dit ? cwk_pkg::EL_DIT : cwk_pkg::EL_DAH;
    end

    straight_start = tip && !tx;
    straight_end   = !tip && tx;
  end

  // Next state.
  always_comb begin
    phase_next       = phase;
    elem_next        = elem;
    phase_start_next = phase_start;
    key_down_next    = key_down;
    elem_len_next    = elem_len;
    dit_mem_next     = dit_mem;
    dah_mem_next     = dah_mem;
    tx_next          = tx;
    if (!cfg.paddle_mode) begin
      if (straight_start) begin
        key_down_next = now;
        tx_next       = 1'b1;
      end else if (straight_end) begin
        tx_next = 1'b0;
      end
    end else begin
      dit_mem_next = dit_mem_upd;
      dah_mem_next = dah_mem_upd;
      if (in_idle) begin
        phase_next = cwk_pkg::PH_IDLE;
      end
      if (send_end) begin
        tx_next          = 1'b0;
        phase_next       = cwk_pkg::PH_SPACE;
        phase_start_next = now;
      end
      if (space_end && dah_mem_upd) begin
        dah_mem_next = 1'b0;
      end else if (space_end && dit_mem_upd) begin
        dit_mem_next = 1'b0;
      end
      if (go_idle) begin
        phase_next = cwk_pkg::PH_IDLE;
        elem_next  = cwk_pkg::EL_NONE;
      end
      if (start_go) begin
        elem_next        = start_el;
        elem_len_next    = (start_el == cwk_pkg::EL_DAH) ?
                           ({1'b0, cfg.dit_len, 1'b0} + {2'b00, cfg.dit_len}) :
                           {2'b00, cfg.dit_len};
        phase_next       = cwk_pkg::PH_SEND;
        phase_start_next = now;
        tx_next          = 1'b1;
      end
    end
  end

  // Result of this tick.
  always_comb begin
    key_diff_next      = now - key_down_next;
    res.transmit_on    = tx_next;
    res.event_code     = cwk_pkg::EV_NONE;
    res.element_is_dah = 1'b0;
    res.element_ms     = '0;
    res.threshold_ms   = cfg.threshold;
    res.tip_pressed    = tip;
    res.ring_pressed   = ring;
    res.key_state      = cwk_pkg::KS_IDLE;
    if (!cfg.paddle_mode) begin
      if (straight_start) begin
        res.event_code = cwk_pkg::EV_START;
      end else if (straight_end) begin
        res.event_code     = cwk_pkg::EV_DONE;
        res.element_ms     = 32'(key_diff);
        res.element_is_dah = (key_diff >= thr_w);
      end
      if (tx_next) begin
        res.key_state = (key_diff_next < thr_w) ? cwk_pkg::KS_DIT : cwk_pkg::KS_DAH;
      end
    end else begin
      if (send_end) begin
        res.event_code     = cwk_pkg::EV_DONE;
        res.element_ms     = 32'(phase_diff);
        res.element_is_dah = (elem == cwk_pkg::EL_DAH);
      end
      if (start_go) begin
        res.event_code = cwk_pkg::EV_START;
      end
      if (tx_next) begin
        res.key_state = (elem_next == cwk_pkg::EL_DAH) ? cwk_pkg::KS_DAH : cwk_pkg::KS_DIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= cwk_pkg::PH_IDLE;
      elem        <= cwk_pkg::EL_NONE;
      phase_start <= '0;
      key_down    <= '0;
      elem_len    <= '0;
      dit_mem     <= 1'b0;
      dah_mem     <= 1'b0;
      tx          <= 1'b0;
    end else if (clear) begin
      phase   <= cwk_pkg::PH_IDLE;
      elem    <= cwk_pkg::EL_NONE;
      dit_mem <= 1'b0;
      dah_mem <= 1'b0;
      tx      <= 1'b0;
    end else if (tick) begin
      phase       <= phase_next;
      elem        <= elem_next;
      phase_start <= phase_start_next;
      key_down    <= key_down_next;
      elem_len    <= elem_len_next;
      dit_mem     <= dit_mem_next;
      dah_mem     <= dah_mem_next;
      tx          <= tx_next;
    end
  end

endmodule

FILE: rtl/cw_iambic_straight_keyer.sv
// Top level of the CW keyer: input register, debouncers, keyer logic and result register.
// Depends on cwk_pkg, cwk_cfg, cwk_debounce and cwk_keyer.
//
//   channel   direction  handshake             payload
//   s_*       in         s_tvalid / s_tready   one tick: time and raw contact levels
//   m_*       out        m_tvalid / m_tready   one result per tick
//   cfg_*     in         cfg_valid / cfg_ready register index and write data
//
// Each tick is held in the input register and then in the result register; one tick per
// cycle is sustained while the result side does not stall.
// The single path of debounce compare and keyer decision lies between the two registers.
// rst is synchronous and returns registers and keyer state to their defaults.
// When the result register is stalled, a tick waits in the input register and s_tready falls.
module cw_iambic_straight_keyer #(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // now_ms[31:0], tip_level[32], ring_level[33], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // transmit_on[0], event_code[2:1], element_is_dah[3],
                                 // element_ms[35:4], threshold_ms[47:36], key_state[49:48],
                                 // tip_pressed[50], ring_pressed[51], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic                  in_valid;
  logic [TIME_WIDTH-1:0] in_now;
  logic                  in_tip;
  logic                  in_ring;
  logic                  fire;
  logic                  tip_pressed, ring_pressed;
  logic                  keyer_clear;
  cwk_pkg::cfg_t         cfg;
  cwk_pkg::res_t         res, out_res;

  assign cfg_ready = 1'b1;
  assign fire      = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_now  <= TIME_WIDTH'(s_tdata[31:0]);
      in_tip  <= s_tdata[32];
      in_ring <= s_tdata[33];
    end
  end

  cwk_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (cfg_valid && cfg_ready),
    .wr_index    (cfg_index),
    .wr_data     (cfg_data),
    .cfg         (cfg),
    .keyer_clear (keyer_clear)
  );

  cwk_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_tip_db (
    .clk       (clk),
    .rst       (rst),
    .tick      (fire),
    .raw       (in_tip),
    .now       (in_now),
    .settle_ms (cfg.settle_ms),
    .pressed   (tip_pressed)
  );

  cwk_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_ring_db (
    .clk       (clk),
    .rst       (rst),
    .tick      (fire),
    .raw       (in_ring),
    .now       (in_now),
    .settle_ms (cfg.settle_ms),
    .pressed   (ring_pressed)
  );

  cwk_keyer #(.TIME_WIDTH(TIME_WIDTH)) u_keyer (
    .clk   (clk),
    .rst   (rst),
    .tick  (fire),
    .clear (keyer_clear),
    .now   (in_now),
    .tip   (tip_pressed),
    .ring  (ring_pressed),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_tdata = {4'd0, out_res};

  // A started element always leaves the key line down.
  a_start_keys: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.event_code == cwk_pkg::EV_START |-> out_res.transmit_on)
    else $error("element started without key line active");

  // A completed element always releases the key line.
  a_done_releases: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.event_code == cwk_pkg::EV_DONE |-> !out_res.transmit_on)
    else $error("element completed with key line still active");

  // Key state reports idle exactly when the key line is up.
  a_state_matches_tx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((out_res.key_state == cwk_pkg::KS_IDLE) == !out_res.transmit_on))
    else $error("key state disagrees with key line");

  // The input side only stalls behind a held tick and a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a stalled result");

endmodule

FILE: bench/cw_iambic_straight_keyer_test.sv
// Self-checking bench for the CW keyer: a directed table followed by random paddle
// and straight-key traffic in several settings, checked against an in-bench keyer model.
// Depends on cwk_pkg and cw_iambic_straight_keyer from rtl/.
`timescale 1ns / 100ps

module cw_iambic_straight_keyer_test;
  import cwk_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_TICKS = 150;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] now;
    logic        tip;
    logic        ring;
    logic [2:0]  idx;
    logic [7:0]  data;
    bit          typed;
    res_t        want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // now_ms[31:0], tip_level[32], ring_level[33], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;   // transmit_on[0], event_code[2:1], element_is_dah[3],
                          // element_ms[35:4], threshold_ms[47:36], key_state[49:48],
                          // tip_pressed[50], ring_pressed[51], zero pad
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  // Keyer model state and its copy of the registers.
  logic        paddle_on, swap_on;
  logic [5:0]  wpm;
  logic [7:0]  mult_q4, debounce;
  logic        contact_stable [2];   // index 0 tip, 1 ring
  logic        contact_raw [2];
  logic [31:0] contact_t [2];
  phase_t      phase;
  elem_t       elem;
  logic [31:0] phase_t0, key_down_ms;
  logic [9:0]  elem_len;
  logic        dit_mem, dah_mem, tx_on;

  res_t        key_results_due [$];
  res_t        seen_result, due_result;
  stim_row_t   directed_rows [$];

  int  src_gap_pct = 0;
  int  sink_stall_pct = 0;
  int  holds_asked = 0;
  int  holds_done = 0;
  int  fail_count = 0;
  int  results_checked = 0;
  int  ticks_sent = 0;
  int  starts_due = 0;
  int  dones_due = 0;
  int  dahs_due = 0;
  int  reg_writes = 0;
  int  quiet_cycles = 0;

  cw_iambic_straight_keyer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] dit_ms_now();
    return 8'(1200 / wpm);
  endfunction

  function automatic logic [11:0] threshold_now();
    int prod;
    prod = dit_ms_now() * mult_q4;
    return prod[15:4];
  endfunction

  function automatic void keyer_clear();
    tx_on = 1'b0;
    phase = PH_IDLE;
    elem = EL_NONE;
    dit_mem = 1'b0;
    dah_mem = 1'b0;
  endfunction

  function automatic void keyer_reset();
    paddle_on = 1'b0;
    wpm = WPM_RST;
    mult_q4 = MULT_RST;
    swap_on = 1'b0;
    debounce = DEBOUNCE_RST;
    for (int i = 0; i < 2; i++) begin
      contact_stable[i] = 1'b1;
      contact_raw[i] = 1'b1;
      contact_t[i] = '0;
    end
    phase_t0 = '0;
    elem_len = '0;
    key_down_ms = '0;
    keyer_clear();
  endfunction

  function automatic void keyer_write_reg(logic [2:0] idx, logic [7:0] data);
    case (idx)
      REG_PADDLE_MODE: begin
        paddle_on = data[0];
        keyer_clear();
      end
      REG_WPM: begin
        wpm = data[5:0];
        if (wpm < WPM_MIN) wpm = WPM_MIN;
        if (wpm > WPM_MAX) wpm = WPM_MAX;
      end
      REG_CLASS_MULT: mult_q4 = data;
      REG_SWAP:       swap_on = data[0];
      REG_DEBOUNCE:   debounce = data;
      default: ;
    endcase
  endfunction

  function automatic logic [1:0] start_element(elem_t e, logic [31:0] now);
    elem = e;
    elem_len = (e == EL_DAH) ? 10'(dit_ms_now() * 3) : 10'(dit_ms_now());
    phase = PH_SEND;
    phase_t0 = now;
    tx_on = 1'b1;
    return EV_START;
  endfunction

  // One millisecond tick of the keyer: debounce, then straight or iambic keying.
  function automatic res_t keyer_tick(logic [31:0] now, logic tip_lv, logic ring_lv);
    res_t        r;
    logic [31:0] el;
    logic [11:0] thr;
    logic        raw [2];
    logic        tip_p, ring_p, dit_p, dah_p;
    r = '0;
    thr = threshold_now();
    raw[0] = tip_lv;
    raw[1] = ring_lv;
    for (int i = 0; i < 2; i++) begin
      if (raw[i] != contact_raw[i]) begin
        contact_raw[i] = raw[i];
        contact_t[i] = now;
      end
      if (now - contact_t[i] >= debounce) contact_stable[i] = contact_raw[i];
    end
    tip_p = !contact_stable[0];
    ring_p = !contact_stable[1];

    if (!paddle_on) begin
      if (tip_p && !tx_on) begin
        key_down_ms = now;
        tx_on = 1'b1;
        r.event_code = EV_START;
      end else if (!tip_p && tx_on) begin
        r.element_ms = now - key_down_ms;
        r.element_is_dah = (r.element_ms >= thr);
        tx_on = 1'b0;
        r.event_code = EV_DONE;
      end
    end else begin
      dit_p = swap_on ? ring_p : tip_p;
      dah_p = swap_on ? tip_p : ring_p;
      if (phase == PH_SEND || phase == PH_SPACE) begin
        if (elem == EL_DIT && dah_p) dah_mem = 1'b1;
        if (elem == EL_DAH && dit_p) dit_mem = 1'b1;
      end
      if (phase == PH_SEND) begin
        el = now - phase_t0;
        if (el >= elem_len) begin
          r.element_ms = el;
          r.element_is_dah = (elem == EL_DAH);
          tx_on = 1'b0;
          r.event_code = EV_DONE;
          phase = PH_SPACE;
          phase_t0 = now;
        end
      end else if (phase == PH_SPACE) begin
        if (now - phase_t0 >= dit_ms_now()) begin
          if (dah_mem) begin
            dah_mem = 1'b0;
            r.event_code = start_element(EL_DAH, now);
          end else if (dit_mem) begin
            dit_mem = 1'b0;
            r.event_code = start_element(EL_DIT, now);
          end else if (dit_p && dah_p) begin
            // Squeeze keeps alternating against the element just sent.
            r.event_code = start_element((elem == EL_DIT) ? EL_DAH : EL_DIT, now);
          end else if (dit_p) begin
            r.event_code = start_element(EL_DIT, now);
          end else if (dah_p) begin
            r.event_code = start_element(EL_DAH, now);
          end else begin
            phase = PH_IDLE;
            elem = EL_NONE;
          end
        end
      end else begin
        // Idle, and the unused phase code that behaves as idle.
        phase = PH_IDLE;
        if (dit_p) r.event_code = start_element(EL_DIT, now);
        else if (dah_p) r.event_code = start_element(EL_DAH, now);
      end
    end

    r.key_state = KS_IDLE;
    if (tx_on) begin
      if (paddle_on) r.key_state = (elem == EL_DAH) ? KS_DAH : KS_DIT;
      else r.key_state = (now - key_down_ms < thr) ? KS_DIT : KS_DAH;
    end
    r.transmit_on = tx_on;
    r.threshold_ms = thr;
    r.tip_pressed = tip_p;
    r.ring_pressed = ring_p;
    return r;
  endfunction

  function automatic res_t key_res(logic tx, logic [1:0] ev, logic dah, logic [31:0] ms,
                                   logic [11:0] thr, logic [1:0] ks, logic tp, logic rp);
    res_t r;
    r.transmit_on = tx;
    r.event_code = ev;
    r.element_is_dah = dah;
    r.element_ms = ms;
    r.threshold_ms = thr;
    r.key_state = ks;
    r.tip_pressed = tp;
    r.ring_pressed = rp;
    return r;
  endfunction

  function automatic stim_row_t tick_row(logic [31:0] now, logic tip, logic ring);
    stim_row_t row;
    row.kind = ROW_TICK;
    row.now = now;
    row.tip = tip;
    row.ring = ring;
    row.idx = '0;
    row.data = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic stim_row_t checked_row(logic [31:0] now, logic tip, logic ring,
                                            res_t want);
    stim_row_t row;
    row = tick_row(now, tip, ring);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [2:0] idx, logic [7:0] data);
    stim_row_t row;
    row = tick_row('0, 1'b1, 1'b1);
    row.kind = ROW_WRITE;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic string show(res_t r);
    return $sformatf("tx=%0b ev=%0d dah=%0b ms=%0d thr=%0d ks=%0d tip=%0b ring=%0b",
                     r.transmit_on, r.event_code, r.element_is_dah, r.element_ms,
                     r.threshold_ms, r.key_state, r.tip_pressed, r.ring_pressed);
  endfunction

  // Entered and left at a falling edge. The expectation is queued once the request
  // is taken, so the model sees ticks in the order the block does.
  task automatic send_tick(logic [31:0] now, logic tip, logic ring, bit typed, res_t want);
    res_t r;
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, ring, tip, now};
    do @(posedge clk); while (!s_tready);
    r = keyer_tick(now, tip, ring);
    if (typed) r = want;
    key_results_due.push_back(r);
    ticks_sent++;
    if (r.event_code == EV_START) starts_due++;
    if (r.event_code == EV_DONE) dones_due++;
    if (r.event_code == EV_DONE && r.element_is_dah) dahs_due++;
    @(negedge clk);
  endtask

  // Registers change only with nothing in flight.
  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    s_tvalid <= 1'b0;
    while (key_results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    keyer_write_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls, and one long hold-off on request from the stimulus.
  always @(negedge clk) begin
    if (holds_done != holds_asked) begin
      m_tready <= 1'b0;
      repeat (HOLD_OFF_CYCLES) @(negedge clk);
      holds_done++;
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_result = m_tdata[51:0];
      if (key_results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result with no tick pending: %s", show(seen_result));
      end else begin
        due_result = key_results_due.pop_front();
        results_checked++;
        if (seen_result !== due_result) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch on result %0d", results_checked);
            $display("  expected %s", show(due_result));
            $display("  actual   %s", show(seen_result));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request taken for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    logic [31:0] clock_ms, pattern_t0, hold_ms;
    logic        tip_want, ring_want, tip_lv, ring_lv;
    int          step_max, hold_max;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    keyer_reset();

    // Defaults give a 60 ms dit and a 120 ms threshold; contacts debounce in 5 ms.
    directed_rows = {
      checked_row(32'd0, 1'b1, 1'b1, key_res(0, EV_NONE, 0, 0, 120, KS_IDLE, 0, 0)),
      checked_row(32'hFFFF_FFFF, 1'b0, 1'b0,
                  key_res(0, EV_NONE, 0, 0, 120, KS_IDLE, 0, 0)),
      // Debounce window measured across the time wrap.
      checked_row(32'd4, 1'b0, 1'b0, key_res(1, EV_START, 0, 0, 120, KS_DIT, 1, 1)),
      checked_row(32'd200, 1'b1, 1'b1, key_res(1, EV_NONE, 0, 0, 120, KS_DAH, 1, 1)),
      checked_row(32'd205, 1'b1, 1'b1, key_res(0, EV_DONE, 1, 201, 120, KS_IDLE, 0, 0)),
      tick_row(32'd300, 1'b0, 1'b1),
      checked_row(32'd305, 1'b0, 1'b1, key_res(1, EV_START, 0, 0, 120, KS_DIT, 1, 0)),
      tick_row(32'd306, 1'b1, 1'b1),
      checked_row(32'd311, 1'b1, 1'b1, key_res(0, EV_DONE, 0, 6, 120, KS_IDLE, 0, 0)),
      // Zero multiplier: every straight element is a dah.
      reg_row(REG_CLASS_MULT, 8'd0),
      reg_row(REG_DEBOUNCE, 8'd0),
      checked_row(32'd400, 1'b0, 1'b1, key_res(1, EV_START, 0, 0, 0, KS_DAH, 1, 0)),
      checked_row(32'd400, 1'b1, 1'b1, key_res(0, EV_DONE, 1, 0, 0, KS_IDLE, 0, 0)),
      // Speed below range clamps to 5 wpm; largest threshold.
      reg_row(REG_WPM, 8'd0),
      reg_row(REG_CLASS_MULT, 8'd255),
      checked_row(32'h8000_0000, 1'b0, 1'b1,
                  key_res(1, EV_START, 0, 0, 3825, KS_DIT, 1, 0)),
      checked_row(32'h8000_0EF1, 1'b1, 1'b1,
                  key_res(0, EV_DONE, 1, 3825, 3825, KS_IDLE, 0, 0)),
      reg_row(REG_UNUSED, 8'hFF),
      // Speed above range clamps to 60 wpm; iambic mode with a 20 ms dit.
      reg_row(REG_WPM, 8'd63),
      reg_row(REG_CLASS_MULT, 8'd16),
      reg_row(REG_PADDLE_MODE, 8'd1),
      // Squeeze from idle sends a dit first, then alternates.
      checked_row(32'd1000, 1'b0, 1'b0, key_res(1, EV_START, 0, 0, 20, KS_DIT, 1, 1)),
      tick_row(32'd1020, 1'b0, 1'b0),
      tick_row(32'd1040, 1'b0, 1'b0),
      tick_row(32'd1100, 1'b1, 1'b0),
      tick_row(32'd1120, 1'b1, 1'b0),
      tick_row(32'd1180, 1'b1, 1'b1),
      tick_row(32'd1200, 1'b1, 1'b1),
      reg_row(REG_SWAP, 8'd1),
      tick_row(32'd2000, 1'b1, 1'b0),
      tick_row(32'd2020, 1'b1, 1'b1),
      tick_row(32'd2040, 1'b1, 1'b1),
      tick_row(32'd3000, 1'b1, 1'b0),
      // Rewriting the same mode still drops the element in progress.
      reg_row(REG_PADDLE_MODE, 8'd1),
      tick_row(32'd3001, 1'b1, 1'b0)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) write_reg(row.idx, row.data);
      else send_tick(row.now, row.tip, row.ring, row.typed, row.want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_PADDLE_MODE, {7'b0, p[0]});
      write_reg(REG_WPM, 8'($urandom_range(63)));
      write_reg(REG_CLASS_MULT, 8'($urandom_range(255)));
      write_reg(REG_SWAP, 8'($urandom_range(1)));
      write_reg(REG_DEBOUNCE, (p == 5) ? 8'd255 : 8'($urandom_range(15)));
      case (p % 4)
        0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_gap_pct = 73; sink_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  sink_stall_pct = 73; end
        default: begin src_gap_pct = 31; sink_stall_pct = 31; end
      endcase

      // Hold times scale with the settings so that elements, squeezes and
      // classification on both sides of the threshold all happen.
      step_max = (dit_ms_now() + debounce) / 10 + 1;
      hold_max = 2 * debounce + 6 * dit_ms_now() + threshold_now() / 2 + 1;
      clock_ms = (p == 3) ? 32'hFFFF_FF00 : $urandom();
      pattern_t0 = clock_ms;
      hold_ms = '0;
      tip_want = 1'b1;
      ring_want = 1'b1;
      for (int k = 0; k < PHASE_TICKS; k++) begin
        if (p == PRESSURE_PHASE && k == 40) holds_asked++;
        if ($urandom_range(99) == 0) clock_ms = $urandom();
        else clock_ms = clock_ms + $urandom_range(1, step_max);
        if (clock_ms - pattern_t0 >= hold_ms) begin
          tip_want = 1'($urandom_range(1));
          ring_want = 1'($urandom_range(1));
          pattern_t0 = clock_ms;
          hold_ms = $urandom_range(1, hold_max);
        end
        tip_lv = tip_want;
        ring_lv = ring_want;
        // Contact bounce for a single tick.
        if ($urandom_range(9) == 0) begin
          if ($urandom_range(1)) tip_lv = ~tip_lv;
          else ring_lv = ~ring_lv;
        end
        send_tick(clock_ms, tip_lv, ring_lv, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    src_gap_pct = 0;
    sink_stall_pct = 0;
    while (key_results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("run: %0d ticks in %0d settings, %0d register writes, %0d results checked",
             ticks_sent, NUM_PHASES + 1, reg_writes, results_checked);
    $display("run: %0d elements started, %0d completed of which %0d dah, %0d failures",
             starts_due, dones_due, dahs_due, fail_count);
    if (fail_count == 0 && key_results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
